### hw/rtl/gcsob_pkg.sv
// Shared types, codes and arithmetic helpers for the glyph coverage blend unit.
// No dependencies; used by gcsob_csr, the top level and the checker.
package gcsob_pkg;

   // configuration register index (word address paddr[3:2])
   typedef enum logic [1:0] {
      REG_STYLE_COLOR   = 2'd0,
      REG_RASTER_FORMAT = 2'd1,
      REG_SURFACE_ORDER = 2'd2
   } reg_index_type;

   // texel formats; the unused code decodes as BGRA color
   localparam logic [1:0] FMT_ALPHA8 = 2'd0;
   localparam logic [1:0] FMT_LCD    = 2'd1;
   localparam logic [1:0] FMT_BGRA   = 2'd2;

   localparam logic CMD_FILL  = 1'b0;
   localparam logic CMD_GLYPH = 1'b1;

   localparam logic ORDER_RGBA = 1'b0;

   localparam logic [7:0] FULL = 8'hFF;

   typedef struct packed {
      logic [31:0] style_color;
      logic [1:0]  raster_format;
      logic        surface_order;
   } cfg_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } px_type;

   // round(x*y/255): floor(v/255) for v < 65536 is (v + 1 + (v >> 8)) >> 8
   function automatic logic [7:0] mul255(input logic [7:0] x, input logic [7:0] y);
      logic [15:0] v;
      logic [15:0] t;
      v = 16'(x) * 16'(y) + 16'd127;
      t = v + 16'd1 + {8'd0, v[15:8]};
      return t[15:8];
   endfunction

   // saturating add of two bytes
   function automatic logic [7:0] sat_add(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[8] ? FULL : s[7:0];
   endfunction

endpackage

### hw/rtl/gcsob_csr.sv
// APB-style configuration registers for the glyph coverage blend unit.
// Depends on gcsob_pkg for the register index codes and cfg_type.
module gcsob_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output gcsob_pkg::cfg_type  cfg
);

   gcsob_pkg::cfg_type       cfg_ff;
   gcsob_pkg::cfg_type       cfg_in;
   gcsob_pkg::reg_index_type index;
   logic                     wr_en;

   assign index  = gcsob_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            gcsob_pkg::REG_STYLE_COLOR:   cfg_in.style_color   = pwdata;
            gcsob_pkg::REG_RASTER_FORMAT: cfg_in.raster_format = pwdata[1:0];
            gcsob_pkg::REG_SURFACE_ORDER: cfg_in.surface_order = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         gcsob_pkg::REG_STYLE_COLOR:   prdata = cfg_ff.style_color;
         gcsob_pkg::REG_RASTER_FORMAT: prdata = {30'd0, cfg_ff.raster_format};
         gcsob_pkg::REG_SURFACE_ORDER: prdata = {31'd0, cfg_ff.surface_order};
         default:                      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/glyph_coverage_source_over_blend_unit.sv
// Top level of the glyph coverage source-over blend unit: four-stage pipeline.
// Depends on gcsob_pkg and gcsob_csr.
//
// Usage:
//   The request channel (req_valid / req_stall) carries one pixel command per
//   transfer: fill or glyph, the atlas texel and the current destination pixel.
//   The response channel (rsp_valid / rsp_stall) returns the blended pixel and
//   a write flag; a glyph whose source alpha is zero comes back unchanged with
//   the write flag low.
//   Style color, texel format and surface byte order sit in the APB registers
//   (0x0, 0x4, 0x8); change them only while no pixel is in flight.
//   Throughput: one pixel per cycle while the response is not stalled; the
//   stages are source alpha, source color, destination scaling, and
//   add/saturate/pack, each at most one 8x8 multiply deep.
//   A stalled response freezes every stage at once and raises req_stall in the
//   same cycle, so nothing is dropped or repeated; bubbles stay in place.
//   Reset clears the valid flags and the APB registers and empties the pipeline.
module glyph_coverage_source_over_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_texel_word,
   input  logic [31:0] req_destination_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_blended_pixel,
   output logic        rsp_write_enable,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   gcsob_pkg::cfg_type cfg;

   gcsob_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic advance;

   // stage 1: source alpha, multiply operands for color, unpacked destination
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff, s1_cmd_in;
   logic [7:0]         s1_alpha_ff, s1_alpha_in;
   gcsob_pkg::px_type  s1_x_ff, s1_x_in;       // a lane unused
   gcsob_pkg::px_type  s1_y_ff, s1_y_in;       // a lane unused
   logic               s1_y_alpha_ff, s1_y_alpha_in;
   gcsob_pkg::px_type  s1_dst_ff, s1_dst_in;
   logic [31:0]        s1_dword_ff;

   // stage 2: premultiplied source, inverse alpha
   logic               s2_valid_ff;
   gcsob_pkg::px_type  s2_src_ff, s2_src_in;
   logic [7:0]         s2_inv_ff, s2_inv_in;
   logic               s2_skip_ff, s2_skip_in;
   gcsob_pkg::px_type  s2_dst_ff;
   logic [31:0]        s2_dword_ff;

   // stage 3: destination scaled by inverse alpha
   logic               s3_valid_ff;
   gcsob_pkg::px_type  s3_src_ff;
   gcsob_pkg::px_type  s3_dm_ff, s3_dm_in;
   logic               s3_skip_ff;
   logic [31:0]        s3_dword_ff;

   // stage 4: output register
   logic               rsp_valid_ff;
   logic [31:0]        rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_we_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blended_pixel = rsp_pixel_ff;
   assign rsp_write_enable  = rsp_we_ff;

   // ---------------- stage 1 ----------------
   logic [7:0]        sr, sg, sb, sa;
   logic [7:0]        t0, t1, t2, t3;
   logic [7:0]        cov_max;
   logic [7:0]        ax, ay;
   gcsob_pkg::px_type cp;

   always_comb begin
      sr = cfg.style_color[31:24];
      sg = cfg.style_color[23:16];
      sb = cfg.style_color[15:8];
      sa = cfg.style_color[7:0];
      t0 = req_texel_word[7:0];
      t1 = req_texel_word[15:8];
      t2 = req_texel_word[23:16];
      t3 = req_texel_word[31:24];
      cov_max = (t0 > t1) ? t0 : t1;
      cov_max = (cov_max > t2) ? cov_max : t2;

      // style color premultiplied by style alpha
      cp.r = gcsob_pkg::mul255(sr, sa);
      cp.g = gcsob_pkg::mul255(sg, sa);
      cp.b = gcsob_pkg::mul255(sb, sa);
      cp.a = sa;

      // multiplying by 255 is exact, so pass-through lanes reuse the multiplier
      ax             = sa;
      ay             = gcsob_pkg::FULL;
      s1_x_in        = cp;
      s1_y_in        = {4{gcsob_pkg::FULL}};
      s1_y_alpha_in  = 1'b0;
      if (req_command == gcsob_pkg::CMD_GLYPH) begin
         case (cfg.raster_format)
            gcsob_pkg::FMT_ALPHA8: begin
               ay            = t3;
               s1_x_in       = {sr, sg, sb, sa};
               s1_y_alpha_in = 1'b1;
            end
            gcsob_pkg::FMT_LCD: begin
               ay      = cov_max;
               s1_y_in = {t0, t1, t2, gcsob_pkg::FULL};
            end
            default: begin
               ax            = t3;
               s1_x_in       = {t2, t1, t0, t3};
               s1_y_alpha_in = 1'b1;
            end
         endcase
      end
      s1_alpha_in = gcsob_pkg::mul255(ax, ay);

      s1_dst_in.g = req_destination_pixel[15:8];
      s1_dst_in.a = req_destination_pixel[31:24];
      if (cfg.surface_order == gcsob_pkg::ORDER_RGBA) begin
         s1_dst_in.r = req_destination_pixel[7:0];
         s1_dst_in.b = req_destination_pixel[23:16];
      end else begin
         s1_dst_in.r = req_destination_pixel[23:16];
         s1_dst_in.b = req_destination_pixel[7:0];
      end

      s1_valid_in = req_valid;
      s1_cmd_in   = req_command;
   end

   // ---------------- stage 2 ----------------
   gcsob_pkg::px_type yy;

   always_comb begin
      yy = s1_y_alpha_ff ? {4{s1_alpha_ff}} : s1_y_ff;
      s2_src_in.r = gcsob_pkg::mul255(s1_x_ff.r, yy.r);
      s2_src_in.g = gcsob_pkg::mul255(s1_x_ff.g, yy.g);
      s2_src_in.b = gcsob_pkg::mul255(s1_x_ff.b, yy.b);
      s2_src_in.a = s1_alpha_ff;
      s2_inv_in   = gcsob_pkg::FULL - s1_alpha_ff;
      s2_skip_in  = (s1_cmd_ff == gcsob_pkg::CMD_GLYPH) && (s1_alpha_ff == 8'd0);
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      s3_dm_in.r = gcsob_pkg::mul255(s2_dst_ff.r, s2_inv_ff);
      s3_dm_in.g = gcsob_pkg::mul255(s2_dst_ff.g, s2_inv_ff);
      s3_dm_in.b = gcsob_pkg::mul255(s2_dst_ff.b, s2_inv_ff);
      s3_dm_in.a = gcsob_pkg::mul255(s2_dst_ff.a, s2_inv_ff);
   end

   // ---------------- stage 4 ----------------
   gcsob_pkg::px_type ov;

   always_comb begin
      ov.r = gcsob_pkg::sat_add(s3_src_ff.r, s3_dm_ff.r);
      ov.g = gcsob_pkg::sat_add(s3_src_ff.g, s3_dm_ff.g);
      ov.b = gcsob_pkg::sat_add(s3_src_ff.b, s3_dm_ff.b);
      ov.a = gcsob_pkg::sat_add(s3_src_ff.a, s3_dm_ff.a);
      if (s3_skip_ff) begin
         rsp_pixel_in = s3_dword_ff;
      end else if (cfg.surface_order == gcsob_pkg::ORDER_RGBA) begin
         rsp_pixel_in = {ov.a, ov.b, ov.g, ov.r};
      end else begin
         rsp_pixel_in = {ov.a, ov.r, ov.g, ov.b};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff     <= s1_cmd_in;
         s1_alpha_ff   <= s1_alpha_in;
         s1_x_ff       <= s1_x_in;
         s1_y_ff       <= s1_y_in;
         s1_y_alpha_ff <= s1_y_alpha_in;
         s1_dst_ff     <= s1_dst_in;
         s1_dword_ff   <= req_destination_pixel;

         s2_src_ff     <= s2_src_in;
         s2_inv_ff     <= s2_inv_in;
         s2_skip_ff    <= s2_skip_in;
         s2_dst_ff     <= s1_dst_ff;
         s2_dword_ff   <= s1_dword_ff;

         s3_src_ff     <= s2_src_ff;
         s3_dm_ff      <= s3_dm_in;
         s3_skip_ff    <= s2_skip_ff;
         s3_dword_ff   <= s2_dword_ff;

         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_we_ff     <= !s3_skip_ff;
      end
   end

endmodule

### hw/rtl/gcsob_checker.sv
// Port-level checks for the glyph coverage blend unit, bound to the top level.
// Depends on gcsob_pkg for the command codes.
module gcsob_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_blended_pixel,
   input logic        rsp_write_enable
);

   // a stalled response holds its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blended_pixel)
                                 && $stable(rsp_write_enable))
      else $error("stalled response changed");

   // backpressure only comes from a stalled, valid response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   // a transfer that meets no stall while it passes the stages shows up as a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // fills are always written back
   a_fill_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == gcsob_pkg::CMD_FILL)
      ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> rsp_valid && rsp_write_enable)
      else $error("fill result not written");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind glyph_coverage_source_over_blend_unit gcsob_checker u_gcsob_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_blended_pixel (rsp_blended_pixel),
   .rsp_write_enable  (rsp_write_enable)
);

### sim/tb.sv
// Self-checking bench for glyph_coverage_source_over_blend_unit: random and directed
// pixels, predicted in place and compared against every response transfer.
// Depends on gcsob_pkg and the unit's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PIXELS_PER_PHASE = 100;

   typedef struct {
      logic        command;
      logic [31:0] texel;
      logic [31:0] dest;
   } pixel_cmd_type;

   typedef struct {
      logic [31:0] pixel;
      logic        write;
   } blended_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = gcsob_pkg::CMD_FILL;
   logic [31:0] req_texel_word = '0;
   logic [31:0] req_destination_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_blended_pixel;
   logic        rsp_write_enable;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   pixel_cmd_type       pixel_backlog[$];
   blended_type         expected_blends[$];
   gcsob_pkg::cfg_type  shadow_cfg = '0;
   int          queued_total = 0;
   int          checked_total = 0;
   int          error_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic        calm = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;

   glyph_coverage_source_over_blend_unit uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // rounded x*y/255
   function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] y);
      int p;
      p = int'(x) * int'(y) + 127;
      return 8'(p / 255);
   endfunction

   function automatic logic [7:0] over_channel(input logic [7:0] s, input logic [7:0] d,
                                               input logic [7:0] inv);
      int v;
      v = int'(s) + int'(scale8(d, inv));
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic void predict_blend(input logic cmd, input logic [31:0] texel,
                                         input logic [31:0] dest, output logic [31:0] pix,
                                         output logic wr);
      gcsob_pkg::px_type s;
      gcsob_pkg::px_type d;
      gcsob_pkg::px_type o;
      logic [7:0] sr, sg, sb, sa, cmax, inv;
      sr = shadow_cfg.style_color[31:24];
      sg = shadow_cfg.style_color[23:16];
      sb = shadow_cfg.style_color[15:8];
      sa = shadow_cfg.style_color[7:0];
      if (cmd == gcsob_pkg::CMD_FILL) begin
         s.a = sa;
         s.r = scale8(sr, sa);
         s.g = scale8(sg, sa);
         s.b = scale8(sb, sa);
      end else begin
         case (shadow_cfg.raster_format)
            gcsob_pkg::FMT_ALPHA8: begin
               s.a = scale8(sa, texel[31:24]);
               s.r = scale8(sr, s.a);
               s.g = scale8(sg, s.a);
               s.b = scale8(sb, s.a);
            end
            gcsob_pkg::FMT_LCD: begin
               cmax = texel[7:0];
               if (texel[15:8] > cmax) cmax = texel[15:8];
               if (texel[23:16] > cmax) cmax = texel[23:16];
               s.a = scale8(sa, cmax);
               s.r = scale8(scale8(sr, sa), texel[7:0]);
               s.g = scale8(scale8(sg, sa), texel[15:8]);
               s.b = scale8(scale8(sb, sa), texel[23:16]);
            end
            default: begin
               // BGRA color; the unused format code lands here too
               s.a = texel[31:24];
               s.r = scale8(texel[23:16], s.a);
               s.g = scale8(texel[15:8], s.a);
               s.b = scale8(texel[7:0], s.a);
            end
         endcase
      end
      if (cmd == gcsob_pkg::CMD_GLYPH && s.a == 8'd0) begin
         pix = dest;
         wr = 1'b0;
         return;
      end
      d.g = dest[15:8];
      d.a = dest[31:24];
      d.r = (shadow_cfg.surface_order == gcsob_pkg::ORDER_RGBA) ? dest[7:0] : dest[23:16];
      d.b = (shadow_cfg.surface_order == gcsob_pkg::ORDER_RGBA) ? dest[23:16] : dest[7:0];
      inv = 8'd255 - s.a;
      o.r = over_channel(s.r, d.r, inv);
      o.g = over_channel(s.g, d.g, inv);
      o.b = over_channel(s.b, d.b, inv);
      o.a = over_channel(s.a, d.a, inv);
      if (shadow_cfg.surface_order == gcsob_pkg::ORDER_RGBA)
         pix = {o.a, o.b, o.g, o.r};
      else
         pix = {o.a, o.r, o.g, o.b};
      wr = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
   endtask

   // request side: one transfer per cycle unless a gap burst is running, the request is stalled or the backlog is empty
   always @(posedge clock) begin : driver
      pixel_cmd_type item;
      logic [31:0]   pix;
      logic          wr;
      blended_type   res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_blend(req_command, req_texel_word, req_destination_pixel, pix, wr);
            res.pixel = pix;
            res.write = wr;
            expected_blends.push_back(res);
            if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               item = pixel_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= item.command;
               req_texel_word <= item.texel;
               req_destination_pixel <= item.dest;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: check each transfer, then pick the next stall value
   always @(posedge clock) begin : monitor
      blended_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blends.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_blended_pixel, '0);
            end else begin
               want = expected_blends.pop_front();
               if (rsp_blended_pixel !== want.pixel)
                  report_mismatch("blended_pixel", rsp_blended_pixel, want.pixel);
               if (rsp_write_enable !== want.write)
                  report_mismatch("write_enable", 32'(rsp_write_enable), 32'(want.write));
               checked_total++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_go && !hold_done) begin
            // long hold so the pipe fills and backs up the request side
            hold_done = 1'b1;
            hold_left = 79;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_register(input gcsob_pkg::reg_index_type idx,
                                 input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic apply_settings(input logic [31:0] style, input logic [1:0] fmt,
                                 input logic order);
      write_register(gcsob_pkg::REG_STYLE_COLOR, style);
      write_register(gcsob_pkg::REG_RASTER_FORMAT, {30'd0, fmt});
      write_register(gcsob_pkg::REG_SURFACE_ORDER, {31'd0, order});
      shadow_cfg.style_color = style;
      shadow_cfg.raster_format = fmt;
      shadow_cfg.surface_order = order;
   endtask

   task automatic queue_pixel(input logic cmd, input logic [31:0] texel,
                              input logic [31:0] dest);
      pixel_cmd_type item;
      item.command = cmd;
      item.texel = texel;
      item.dest = dest;
      pixel_backlog.push_back(item);
      queued_total++;
   endtask

   task automatic drain;
      while (checked_total != queued_total) @(posedge clock);
   endtask

   // bytes lean toward the ends of the range, where rounding and skips live
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      apply_settings(32'hFFFFFFFF, gcsob_pkg::FMT_ALPHA8, 1'b0);
      queue_pixel(gcsob_pkg::CMD_FILL, 32'h00000000, 32'h00000000);
      queue_pixel(gcsob_pkg::CMD_FILL, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h00FFFFFF, 32'h12345678);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'hFF000000, 32'h80808080);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h80000000, 32'hFFFFFFFF);
      drain();

      apply_settings(32'h336699CC, gcsob_pkg::FMT_LCD, 1'b1);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'hFF000000, 32'hA1B2C3D4);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h00FF8040, 32'h40302010);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h00FFFFFF, 32'hFFFFFFFF);
      queue_pixel(gcsob_pkg::CMD_FILL, 32'h00000000, 32'h7F7F7F7F);
      drain();

      apply_settings(32'h00000000, gcsob_pkg::FMT_BGRA, 1'b0);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h00FFFFFF, 32'hDEADBEEF);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'hFFFFFFFF, 32'h00000000);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h80102030, 32'hFFFFFFFF);
      queue_pixel(gcsob_pkg::CMD_FILL, 32'hFFFFFFFF, 32'hCAFEF00D);
      drain();

      apply_settings(32'hFF0080FF, 2'd3, 1'b1);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h7F405060, 32'h11223344);
      queue_pixel(gcsob_pkg::CMD_GLYPH, 32'h00FFFFFF, 32'h55667788);
      queue_pixel(gcsob_pkg::CMD_FILL, 32'h00000000, 32'hFF00FF00);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1) calm <= 1'b1;
         apply_settings(pick_word(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         for (int n = 0; n < PIXELS_PER_PHASE; n++)
            queue_pixel(($urandom_range(0, 3) == 0) ? gcsob_pkg::CMD_FILL
                                                     : gcsob_pkg::CMD_GLYPH,
                        pick_word(), pick_word());
         if (ph == 1) hold_go <= 1'b1;
         drain();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
